FILE: rtl/bdq_pkg.sv
package bdq_pkg;

	localparam logic [1:0] ACT_PUSH_FRONT = 2'd0;
	localparam logic [1:0] ACT_PUSH_BACK  = 2'd1;
	localparam logic [1:0] ACT_POP_FRONT  = 2'd2;
	localparam logic [1:0] ACT_SEARCH     = 2'd3;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_EMPTY     = 2'd1;
	localparam logic [1:0] STAT_FULL      = 2'd2;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [3:0]         found_position;
		logic signed [31:0] front_value;
		logic signed [31:0] back_value;
		logic               is_empty;
		logic [4:0]         entry_count;
	} rsp_t;

endpackage

FILE: rtl/bdq_ram.sv
module bdq_ram #(
	parameter int DEPTH      = 16,
	parameter int WORD_WIDTH = 32,
	parameter int AW         = 4
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  logic [WORD_WIDTH-1:0] wdata,
	input  logic [AW-1:0]         raddr,
	output logic [WORD_WIDTH-1:0] rdata
);

	logic [WORD_WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/bounded_deque_with_search.sv
// channel   | handshake          | payload
// ----------+--------------------+--------------------------------------
// request   | start & !busy      | req : action, value
// result    | done (one cycle)   | rsp : status, position, front, back,
//           |                    |       empty flag, count
// Push, pop to empty and any refused request: result shows in the cycle after accept.
// Pop leaving entries: goes through ST_POP for one read of the RAM for the new front.
// Search reads one entry per cycle from the front until a hit or until every held
// entry has been compared. busy covers a pop read or a search scan; results
// cannot be stalled, so the next request may be taken as a result shows. Reset
// clears state, front pointer, count and done only.
module bounded_deque_with_search #(
	parameter int DEPTH      = 16,
	parameter int WORD_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  bdq_pkg::req_t req,
	output logic          busy,
	output logic          done,
	output bdq_pkg::rsp_t rsp
);
	import bdq_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
	localparam logic [IW:0]   DEPTH_W  = (IW + 1)'(DEPTH);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_POP  = 2'd1;
	localparam logic [1:0] ST_SRCH = 2'd2;

	logic [1:0]            state_q, state_n;
	logic [IW-1:0]         front_q, front_n;
	logic [CW-1:0]         cnt_q, cnt_n;
	logic [WORD_WIDTH-1:0] fval_q, fval_n, bval_q, bval_n;
	logic [WORD_WIDTH-1:0] key_q, key_n;
	logic [IW-1:0]         idx_q, idx_n;
	logic [IW-1:0]         ptr_q, ptr_n;

	logic                  emit;
	logic [1:0]            stat;
	logic [IW-1:0]         pos;

	logic                  we;
	logic [IW-1:0]         waddr, raddr;
	logic [WORD_WIDTH-1:0] rdata;

	logic [WORD_WIDTH+31:0] word_x;
	logic [WORD_WIDTH-1:0]  word;
	logic [IW:0]            back_sum;
	logic [IW-1:0]          back_wr, front_dec, front_inc, ptr_inc;
	logic                   accept;

	function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] x);
		ring_inc = (x == LAST_IDX) ? '0 : x + 1'b1;
	endfunction

	assign accept   = start && !busy;
	assign busy     = (state_q != ST_IDLE);
	assign word_x   = {{WORD_WIDTH{1'b0}}, req.value};
	assign word     = word_x[WORD_WIDTH-1:0];

	assign back_sum  = {1'b0, front_q} + (IW + 1)'(cnt_q);
	assign back_wr   = (back_sum >= DEPTH_W) ? IW'(back_sum - DEPTH_W) : back_sum[IW-1:0];
	assign front_dec = (front_q == '0) ? LAST_IDX : front_q - 1'b1;
	assign front_inc = ring_inc(front_q);
	assign ptr_inc   = ring_inc(ptr_q);

	bdq_ram #(
		.DEPTH      (DEPTH),
		.WORD_WIDTH (WORD_WIDTH),
		.AW         (IW)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (word),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		state_n = state_q;
		front_n = front_q;
		cnt_n   = cnt_q;
		fval_n  = fval_q;
		bval_n  = bval_q;
		key_n   = key_q;
		idx_n   = idx_q;
		ptr_n   = ptr_q;
		emit    = 1'b0;
		stat    = STAT_OK;
		pos     = '0;
		we      = 1'b0;
		waddr   = back_wr;
		raddr   = ptr_q;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (req.action)
						ACT_PUSH_FRONT: begin
							emit = 1'b1;
							if (cnt_q == FULL_CNT) begin
								stat = STAT_FULL;
							end else begin
								we      = 1'b1;
								waddr   = front_dec;
								front_n = front_dec;
								cnt_n   = cnt_q + 1'b1;
								fval_n  = word;
								if (cnt_q == '0) bval_n = word;
							end
						end
						ACT_PUSH_BACK: begin
							emit = 1'b1;
							if (cnt_q == FULL_CNT) begin
								stat = STAT_FULL;
							end else begin
								we     = 1'b1;
								cnt_n  = cnt_q + 1'b1;
								bval_n = word;
								if (cnt_q == '0) fval_n = word;
							end
						end
						ACT_POP_FRONT: begin
							if (cnt_q == '0) begin
								emit = 1'b1;
								stat = STAT_EMPTY;
							end else begin
								front_n = front_inc;
								cnt_n   = cnt_q - 1'b1;
								raddr   = front_inc;
								// new front comes from the RAM unless nothing is left
								if (cnt_q == CW'(1)) begin
									emit = 1'b1;
								end else begin
									state_n = ST_POP;
								end
							end
						end
						ACT_SEARCH: begin
							if (cnt_q == '0) begin
								emit = 1'b1;
								stat = STAT_NOT_FOUND;
							end else begin
								raddr   = front_q;
								ptr_n   = front_inc;
								idx_n   = '0;
								key_n   = word;
								state_n = ST_SRCH;
							end
						end
						default: ;
					endcase
				end
			end
			ST_POP: begin
				fval_n  = rdata;
				emit    = 1'b1;
				state_n = ST_IDLE;
			end
			ST_SRCH: begin
				// rdata holds entry idx_q; the next entry is read meanwhile
				raddr = ptr_q;
				ptr_n = ptr_inc;
				idx_n = idx_q + 1'b1;
				if (rdata == key_q) begin
					emit    = 1'b1;
					pos     = idx_q;
					state_n = ST_IDLE;
				end else if (CW'(idx_q) + 1'b1 == cnt_q) begin
					emit    = 1'b1;
					stat    = STAT_NOT_FOUND;
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			front_q <= '0;
			cnt_q   <= '0;
			done    <= 1'b0;
		end else begin
			state_q <= state_n;
			front_q <= front_n;
			cnt_q   <= cnt_n;
			done    <= emit;
		end
	end

	logic [IW+3:0]          pos_x;
	logic [CW+4:0]          cnt_x;
	logic [WORD_WIDTH+31:0] fval_x, bval_x;
	logic                   empty_n;

	assign pos_x   = {4'b0, pos};
	assign cnt_x   = {5'b0, cnt_n};
	assign fval_x  = {32'b0, fval_n};
	assign bval_x  = {32'b0, bval_n};
	assign empty_n = (cnt_n == '0);

	always_ff @(posedge clk) begin
		fval_q <= fval_n;
		bval_q <= bval_n;
		key_q  <= key_n;
		idx_q  <= idx_n;
		ptr_q  <= ptr_n;
		if (emit) begin
			rsp.status         <= stat;
			rsp.found_position <= pos_x[3:0];
			rsp.front_value    <= empty_n ? '0 : fval_x[31:0];
			rsp.back_value     <= empty_n ? '0 : bval_x[31:0];
			rsp.is_empty       <= empty_n;
			rsp.entry_count    <= cnt_x[4:0];
		end
	end

endmodule
